// ===== src/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, codes and character helpers for the decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Characters with a special meaning in form-urlencoded text.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // What the back has to do with a queued word.
    localparam logic [1:0] KIND_PASS   = 2'd0;  // emit data as it stands
    localparam logic [1:0] KIND_DROP   = 2'd1;  // emit nothing
    localparam logic [1:0] KIND_ESCAPE = 2'd2;  // evaluate the two escape chars

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;   // pass byte, or second escape character
        logic [7:0] first;  // first escape character
        logic       last;
    } upd_word_t;

    // Hex digit value: bit 4 set when the character is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Whitespace as a C library sees it: space, tab, LF, VT, FF, CR.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ===== src/url_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder core
// Decodes form-urlencoded text one byte per word, with one result per byte.
// ----------------------------------------------------------------------------
// Usage:
// The input side behaves as a queue: drive in_byte and end_of_string with
// push high; the word is taken at a clock edge where full is low. Mark the
// last byte of each string with end_of_string.
// The result side behaves as a queue too: while empty is low, out_byte,
// byte_valid and string_done show the oldest result, and it is removed at a
// clock edge where pop is high. Every input word gives exactly one result.
// byte_valid is low for the '%' and first escape character, for an escape
// whose value is zero or not a number, and out_byte is then zero.
// An accepted word passes first into the front-to-back queue and then into
// the output register, after which empty goes low.
// Throughput is one word per cycle while the receiver does not stall, set by
// the combinational classify in the front and escape evaluation in the back.
// Reset clears the escape phase, the queue and the output register's full
// flag; no result is pending afterwards. When the receiver stalls, the output
// register holds its word, the two-entry queue fills, and full rises.
// ----------------------------------------------------------------------------
module url_percent_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_done
);
    import upd_pkg::*;

    upd_word_t wr_word;
    upd_word_t rd_word;
    logic      q_write;
    logic      q_read;
    logic      q_full;
    logic      q_empty;

    // The front keeps the escape phase and tags each byte with its handling.
    upd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_write       (q_write),
        .q_word        (wr_word)
    );

    // The queue lets the front keep accepting while the back is stalled.
    upd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_write),
        .wr_word (wr_word),
        .rd_en   (q_read),
        .rd_word (rd_word),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back computes escape values and owns the result register.
    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_word      (rd_word),
        .q_empty     (q_empty),
        .q_read      (q_read),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done)
    );

    assign full = q_full;

endmodule

// ===== src/upd_front.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder front
// Accepts bytes, tracks the escape phase and classifies each byte.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       in_byte,
    input  logic             end_of_string,
    input  logic             q_full,
    output logic             q_write,
    output upd_pkg::upd_word_t q_word
);
    import upd_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic       accept;

    assign accept  = push && !q_full;
    assign q_write = accept;

    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        q_word.kind  = KIND_PASS;
        q_word.data  = in_byte;
        q_word.first = first_reg;
        q_word.last  = end_of_string;
        case (phase_reg)
            PH_FIRST:
            begin
                q_word.kind = KIND_DROP;
                first_next  = in_byte;
                phase_next  = PH_SECOND;
            end
            PH_SECOND:
            begin
                q_word.kind = KIND_ESCAPE;
                phase_next  = PH_IDLE;
            end
            default:
            begin
                if (in_byte == CH_PERCENT) begin
                    q_word.kind = KIND_DROP;
                    phase_next  = PH_FIRST;
                end
                else if (in_byte == CH_PLUS) begin
                    q_word.data = CH_SPACE;
                    phase_next  = PH_IDLE;
                end
                else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
        // An escape never spans two strings.
        if (end_of_string) begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            first_reg <= 8'd0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== src/upd_queue.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module upd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  upd_pkg::upd_word_t wr_word,
    input  logic               rd_en,
    output upd_pkg::upd_word_t rd_word,
    output logic               q_full,
    output logic               q_empty
);
    import upd_pkg::*;

    upd_word_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_wr, do_rd;

    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_word = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count exceeds depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/upd_back.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder back
// Evaluates escapes and holds the decoded word in the output register.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  upd_pkg::upd_word_t q_word,
    input  logic               q_empty,
    output logic               q_read,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               string_done
);
    import upd_pkg::*;

    logic       full_reg;
    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       done_reg;
    logic [4:0] hex_a, hex_b;
    logic [7:0] esc_value;
    logic [7:0] res_byte;
    logic       res_valid;
    logic       load;

    assign hex_a = hex_digit(q_word.first);
    assign hex_b = hex_digit(q_word.data);

    always_comb
    begin
        esc_value = 8'd0;
        if (hex_a[4]) begin
            esc_value = hex_b[4] ? {hex_a[3:0], hex_b[3:0]} : {4'd0, hex_a[3:0]};
        end
        else if (is_blank(q_word.first) || q_word.first == CH_PLUS) begin
            esc_value = hex_b[4] ? {4'd0, hex_b[3:0]} : 8'd0;
        end
    end

    always_comb
    begin
        case (q_word.kind)
            KIND_PASS:
            begin
                res_byte  = q_word.data;
                res_valid = 1'b1;
            end
            KIND_ESCAPE:
            begin
                res_byte  = esc_value;
                res_valid = (esc_value != 8'd0);
            end
            default:
            begin
                res_byte  = 8'd0;
                res_valid = 1'b0;
            end
        endcase
    end

    // The output register takes a new word when it is free or drains this cycle.
    assign load   = !q_empty && (!full_reg || pop);
    assign q_read = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end
        else if (load) begin
            full_reg <= 1'b1;
        end
        else if (pop) begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg  <= res_byte;
            valid_reg <= res_valid;
            done_reg  <= q_word.last;
        end
    end

    assign empty       = !full_reg;
    assign out_byte    = byte_reg;
    assign byte_valid  = valid_reg;
    assign string_done = done_reg;

endmodule
